>>> rtl/pst_pkg.sv
// Shared constants and types for the prime sieve prefix table.
`default_nettype none
package pst_pkg;

  localparam int MAX_VALUE  = 8192;
  localparam int MAX_PRIMES = 1024;

  localparam int VAL_W   = 14;
  localparam int CNT_W   = 11;
  localparam int SUM_W   = 24;
  localparam int MAP_AW  = $clog2(MAX_VALUE + 1);
  localparam int PTR_W   = MAP_AW + 1;
  localparam int ENT_AW  = $clog2(MAX_PRIMES);
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 14;

  localparam logic [CFG_IW-1:0] REG_SIEVE_LIMIT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PRIME_COUNT = 2'd1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SUM_W-1:0] sum;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/pst_entry_ram.sv
// Table memory holding each collected prime with its running prefix sum.
`default_nettype none
module pst_entry_ram
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ENT_AW-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ENT_AW-1:0] raddr,
  output entry_t                 rdata
);

  entry_t mem [0:MAX_PRIMES-1];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/prime_sieve_prefix_table.sv
// Prime table engine: sieve build on demand, then k-th prime and prefix sum lookup.
// With the table built, a request goes through acceptance, table memory read and result
// load, which waits while an earlier result is held by out_stall; no new request is taken
// until the load is done. A build runs on the first request after reset or a sieve limit
// or prime count write: clearing values 0 to limit, sieving, then collecting primes from 2
// up to the limit or the prime count. Synchronous active-low reset.
`default_nettype none
module prime_sieve_prefix_table
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CNT_W-1:0]  in_query_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_prime_value,
  output logic [SUM_W-1:0]       out_prime_sum,
  output logic                   out_found,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_SV_RD   = 4'd2;
  localparam logic [3:0] S_SV_CHK  = 4'd3;
  localparam logic [3:0] S_MARK    = 4'd4;
  localparam logic [3:0] S_COL_RD  = 4'd5;
  localparam logic [3:0] S_COL_CHK = 4'd6;
  localparam logic [3:0] S_QRY_RD  = 4'd7;
  localparam logic [3:0] S_QRY_OUT = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [VAL_W-1:0] sieve_limit_r, sieve_limit_nxt;
  logic [CNT_W-1:0] prime_count_r, prime_count_nxt;
  logic             table_ready_r, table_ready_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [PTR_W-1:0] i_r, i_nxt;
  logic [PTR_W-1:0] sq_r, sq_nxt;
  logic [PTR_W-1:0] j_r, j_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_found_r, out_found_nxt;

  logic [SUM_W-1:0] add_a, add_b, add_y;
  logic [VAL_W-1:0] lim;
  logic [CNT_W-1:0] cap;
  logic [PTR_W-1:0] lim_p;

  logic              map_mem [0:MAX_VALUE];
  logic              map_q_r;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic              map_wdata;
  logic [MAP_AW-1:0] map_raddr;

  logic              ent_we;
  entry_t            ent_wdata;
  entry_t            ent_q;
  logic [ENT_AW-1:0] ent_raddr;
  logic              hit;

  assign lim   = (sieve_limit_r > VAL_W'(MAX_VALUE)) ? VAL_W'(MAX_VALUE) : sieve_limit_r;
  assign cap   = (prime_count_r > CNT_W'(MAX_PRIMES)) ? CNT_W'(MAX_PRIMES) : prime_count_r;
  assign lim_p = PTR_W'(lim);
  assign add_y = add_a + add_b;

  assign ent_raddr = ENT_AW'(k_r - CNT_W'(1));
  assign ent_wdata = '{value: ptr_r[VAL_W-1:0], sum: add_y};
  assign hit       = (k_r != '0) && (k_r <= found_r);

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_prime_sum   = out_sum_r;
  assign out_found       = out_found_r;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q_r <= map_mem[map_raddr];
  end

  pst_entry_ram u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (found_r[ENT_AW-1:0]),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  always_comb begin
    state_nxt       = state_r;
    sieve_limit_nxt = sieve_limit_r;
    prime_count_nxt = prime_count_r;
    table_ready_nxt = table_ready_r;
    found_nxt       = found_r;
    k_nxt           = k_r;
    ptr_nxt         = ptr_r;
    i_nxt           = i_r;
    sq_nxt          = sq_r;
    j_nxt           = j_r;
    sum_nxt         = sum_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_sum_nxt     = out_sum_r;
    out_found_nxt   = out_found_r;
    add_a           = '0;
    add_b           = '0;
    map_we          = 1'b0;
    map_waddr       = ptr_r[MAP_AW-1:0];
    map_wdata       = 1'b0;
    map_raddr       = ptr_r[MAP_AW-1:0];
    ent_we          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt = in_query_index;
          if (table_ready_r) begin
            state_nxt = S_QRY_RD;
          end else begin
            ptr_nxt   = '0;
            found_nxt = '0;
            sum_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = ptr_r[MAP_AW-1:0];
        map_wdata = 1'b0;
        if (ptr_r >= lim_p) begin
          i_nxt     = PTR_W'(2);
          sq_nxt    = PTR_W'(4);
          state_nxt = S_SV_RD;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
      S_SV_RD: begin
        if (sq_r > lim_p) begin
          ptr_nxt   = PTR_W'(2);
          state_nxt = S_COL_RD;
        end else begin
          map_raddr = i_r[MAP_AW-1:0];
          state_nxt = S_SV_CHK;
        end
      end
      S_SV_CHK: begin
        if (map_q_r) begin
          add_a     = SUM_W'(sq_r);
          add_b     = SUM_W'({i_r, 1'b1});
          sq_nxt    = add_y[PTR_W-1:0];
          i_nxt     = i_r + PTR_W'(1);
          state_nxt = S_SV_RD;
        end else begin
          j_nxt     = sq_r;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (j_r > lim_p) begin
          add_a     = SUM_W'(sq_r);
          add_b     = SUM_W'({i_r, 1'b1});
          sq_nxt    = add_y[PTR_W-1:0];
          i_nxt     = i_r + PTR_W'(1);
          state_nxt = S_SV_RD;
        end else begin
          map_we    = 1'b1;
          map_waddr = j_r[MAP_AW-1:0];
          map_wdata = 1'b1;
          add_a     = SUM_W'(j_r);
          add_b     = SUM_W'(i_r);
          j_nxt     = add_y[PTR_W-1:0];
        end
      end
      S_COL_RD: begin
        if ((ptr_r > lim_p) || (found_r >= cap)) begin
          table_ready_nxt = 1'b1;
          state_nxt       = S_QRY_RD;
        end else begin
          map_raddr = ptr_r[MAP_AW-1:0];
          state_nxt = S_COL_CHK;
        end
      end
      S_COL_CHK: begin
        if (!map_q_r) begin
          ent_we    = 1'b1;
          add_a     = sum_r;
          add_b     = SUM_W'(ptr_r);
          sum_nxt   = add_y;
          found_nxt = found_r + CNT_W'(1);
        end
        ptr_nxt   = ptr_r + PTR_W'(1);
        state_nxt = S_COL_RD;
      end
      S_QRY_RD: begin
        state_nxt = S_QRY_OUT;
      end
      S_QRY_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = hit ? ent_q.value : '0;
          out_sum_nxt   = hit ? ent_q.sum : '0;
          out_found_nxt = (k_r == '0) || hit;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIEVE_LIMIT: begin
          sieve_limit_nxt = cfg_data[VAL_W-1:0];
          table_ready_nxt = 1'b0;
        end
        REG_PRIME_COUNT: begin
          prime_count_nxt = cfg_data[CNT_W-1:0];
          table_ready_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sieve_limit_r <= VAL_W'(8192);
      prime_count_r <= CNT_W'(1024);
      table_ready_r <= 1'b0;
      found_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sieve_limit_r <= sieve_limit_nxt;
      prime_count_r <= prime_count_nxt;
      table_ready_r <= table_ready_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    ptr_r       <= ptr_nxt;
    i_r         <= i_nxt;
    sq_r        <= sq_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_sum_r   <= out_sum_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule
`default_nettype wire

>>> verif/prime_sieve_prefix_table_tb.sv
// Self-checking testbench for the prime sieve prefix table with a scoreboard class.
`default_nettype none
import pst_pkg::*;

typedef struct packed {
  logic [VAL_W-1:0] value;
  logic [SUM_W-1:0] sum;
  logic             found;
} prime_answer_t;

class prime_table_board;
  logic [VAL_W-1:0]  limit_reg;
  logic [CNT_W-1:0]  count_reg;
  bit                built;
  logic [VAL_W-1:0]  prime_tab [MAX_PRIMES];
  logic [SUM_W-1:0]  sum_tab [MAX_PRIMES+1];
  int unsigned       n_primes;
  prime_answer_t     answers_due [$];
  int                errors;

  function new();
    limit_reg = VAL_W'(MAX_VALUE);
    count_reg = CNT_W'(MAX_PRIMES);
    built     = 0;
    n_primes  = 0;
    errors    = 0;
  endfunction

  function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    if (idx == REG_SIEVE_LIMIT) begin
      limit_reg = data[VAL_W-1:0];
      built = 0;
    end else if (idx == REG_PRIME_COUNT) begin
      count_reg = data[CNT_W-1:0];
      built = 0;
    end
  endfunction

  function void build();
    bit composite [MAX_VALUE+1];
    int unsigned lim;
    int unsigned cap;
    int unsigned i;
    int unsigned j;
    lim = (limit_reg > MAX_VALUE) ? MAX_VALUE : limit_reg;
    cap = (count_reg > MAX_PRIMES) ? MAX_PRIMES : count_reg;
    for (i = 0; i <= MAX_VALUE; i++) composite[i] = 0;
    for (i = 2; i * i <= lim; i++) begin
      if (!composite[i]) begin
        for (j = i * i; j <= lim; j += i) composite[j] = 1;
      end
    end
    n_primes = 0;
    sum_tab[0] = '0;
    for (i = 2; i <= lim && n_primes < cap; i++) begin
      if (!composite[i]) begin
        prime_tab[n_primes] = VAL_W'(i);
        sum_tab[n_primes+1] = sum_tab[n_primes] + SUM_W'(i);
        n_primes++;
      end
    end
    built = 1;
  endfunction

  function int unsigned table_size();
    if (!built) build();
    return n_primes;
  endfunction

  function int pending();
    return answers_due.size();
  endfunction

  function void note_query(logic [CNT_W-1:0] k);
    prime_answer_t a;
    if (!built) build();
    if (k == 0) begin
      a = '{value: '0, sum: '0, found: 1'b1};
    end else if (k <= n_primes) begin
      a = '{value: prime_tab[k-1], sum: sum_tab[k], found: 1'b1};
    end else begin
      a = '{value: '0, sum: '0, found: 1'b0};
    end
    answers_due.insert(answers_due.size(), a);
  endfunction

  function void check_result(logic [VAL_W-1:0] value, logic [SUM_W-1:0] sum,
                             logic found);
    prime_answer_t a;
    if (answers_due.size() == 0) begin
      $display("%0t: result with no request waiting: value %0d sum %0d found %0d",
               $time, value, sum, found);
      errors++;
      return;
    end
    a = answers_due.pop_front();
    if (value !== a.value) begin
      $display("%0t: prime_value expected %0d, got %0d", $time, a.value, value);
      errors++;
    end
    if (sum !== a.sum) begin
      $display("%0t: prime_sum expected %0d, got %0d", $time, a.sum, sum);
      errors++;
    end
    if (found !== a.found) begin
      $display("%0t: found expected %0d, got %0d", $time, a.found, found);
      errors++;
    end
  endfunction
endclass

module prime_sieve_prefix_table_tb;
  localparam int QUIET_LIMIT = 300000;
  localparam int PHASE_ITEMS = 160;
  localparam logic [CFG_IW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPARE_B = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CNT_W-1:0]  in_query_index;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  out_prime_value;
  logic [SUM_W-1:0]  out_prime_sum;
  logic              out_found;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  prime_table_board sb;
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  prime_sieve_prefix_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_query_index  (in_query_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prime_value (out_prime_value),
    .out_prime_sum   (out_prime_sum),
    .out_found       (out_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_left % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_query(in_query_index);
      if (out_valid && !out_stall) begin
        sb.check_result(out_prime_value, out_prime_sum, out_found);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_query(input int k);
    in_valid       <= 1'b1;
    in_query_index <= CNT_W'(k);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_in(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_table(input int lim, input int cnt);
    drain();
    cfg_write(REG_SIEVE_LIMIT, lim);
    cfg_write(REG_PRIME_COUNT, cnt);
  endtask

  task automatic run_queries(input int n_items);
    int sent;
    int burst;
    int span;
    int k;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      while (burst > 0 && sent < n_items) begin
        span = sb.table_size() + 2;
        if (span > 2047) span = 2047;
        k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, span) : $urandom_range(0, 2047);
        push_query(k);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_in($urandom_range(1, 12));
    end
  endtask

  initial begin
    int lim;
    int cnt;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_query_index = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    push_query(0);
    push_query(1);
    push_query(1024);
    push_query(1025);
    push_query(2047);
    push_query(1023);
    push_query(2);
    push_query(512);
    idle_in(3);
    push_query(5);

    set_table(16383, 2047);
    push_query(1024);
    push_query(1025);
    push_query(0);

    set_table(1, 5);
    push_query(1);
    push_query(0);

    set_table(0, 0);
    push_query(1);

    set_table(100, 0);
    push_query(1);
    push_query(0);

    drain();
    cfg_write(REG_SPARE_A, 16383);
    cfg_write(REG_SPARE_B, 0);
    cfg_write(REG_PRIME_COUNT, 4);
    push_query(4);
    push_query(5);
    push_query(3);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin lim = 8192; cnt = 1024; end
        1: begin lim = 2; cnt = 1; end
        2: begin lim = $urandom_range(2, 8192); cnt = 1024; end
        3: begin lim = 16383; cnt = $urandom_range(0, 16383); end
        default: begin lim = $urandom_range(2, 1200); cnt = $urandom_range(1, 1024); end
      endcase
      set_table(lim, cnt);
      run_queries(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/pst_pkg.sv
rtl/pst_entry_ram.sv
rtl/prime_sieve_prefix_table.sv
verif/prime_sieve_prefix_table_tb.sv
